// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slc assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slc assertion failed");

`endif

// ----- rtl/slc_pkg.sv -----
// Shared types and constants for the set-associative LRU cache lookup.
// No dependencies.
package slc_pkg;

  localparam int DEF_SET_INDEX_BITS = 6;
  localparam int DEF_MAX_WAYS       = 8;
  localparam int DEF_ADDR_WIDTH     = 64;

  localparam int ADDR_IN_W = 64;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 32;
  localparam int WAY_OUT_W = 3;
  localparam int SET_OUT_W = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [5:0] block_bits;
    logic [3:0] ways_in_use;
  } cfg_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic [WAY_OUT_W-1:0] way_used;
    logic [SET_OUT_W-1:0] set_number;
    logic [COUNT_W-1:0]   hit_count;
    logic [COUNT_W-1:0]   miss_count;
    logic [COUNT_W-1:0]   eviction_count;
  } res_t;

endpackage

// ----- rtl/slc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/slc_front.sv -----
// Front end: splits an address into set index and tag under the current config.
// Depends on slc_pkg.
module slc_front #(
  parameter int SET_INDEX_BITS = slc_pkg::DEF_SET_INDEX_BITS,
  parameter int ADDR_WIDTH     = slc_pkg::DEF_ADDR_WIDTH,
  localparam int SETW = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1
) (
  input  logic [slc_pkg::ADDR_IN_W-1:0] address,
  input  slc_pkg::cfg_t                 cfg,
  output logic [SETW-1:0]               set_idx,
  output logic [ADDR_WIDTH-1:0]         tag
);

  logic [ADDR_WIDTH-1:0] blk;
  logic [2:0]            sb_eff;
  logic [SETW-1:0]       set_mask;

  always_comb begin
    // set_bits beyond the index width acts as the full index width
    sb_eff   = (32'(cfg.set_bits) > SET_INDEX_BITS) ? 3'(SET_INDEX_BITS) : cfg.set_bits;
    blk      = address[ADDR_WIDTH-1:0] >> cfg.block_bits;
    set_mask = (SET_INDEX_BITS > 0) ? ~({SETW{1'b1}} << sb_eff) : '0;
    set_idx  = blk[SETW-1:0] & set_mask;
    tag      = blk >> sb_eff;
  end

endmodule

// ----- rtl/slc_fifo.sv -----
// Two-entry request queue between the front end and the back end.
// No dependencies.
module slc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/slc_back.sv -----
// Back end: row read-modify-write of tags, valid bits and recency order,
// counters and the result register. Depends on slc_pkg and slc_ram.
module slc_back #(
  parameter int SET_INDEX_BITS = slc_pkg::DEF_SET_INDEX_BITS,
  parameter int MAX_WAYS       = slc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH     = slc_pkg::DEF_ADDR_WIDTH,
  localparam int SETW = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [3:0]            ways_in_use,
  input  logic                  req_valid,
  input  logic [SETW-1:0]       req_set,
  input  logic [ADDR_WIDTH-1:0] req_tag,
  output logic                  req_pop,
  output logic                  clearing,
  output logic                  res_valid,
  input  logic                  res_stall,
  output slc_pkg::res_t         res
);

  localparam int NUM_SETS = 1 << SET_INDEX_BITS;
  localparam int WAYW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW      = $clog2(MAX_WAYS + 1);
  localparam int TAGS_W   = MAX_WAYS * ADDR_WIDTH;
  localparam int REC_OFF  = TAGS_W + MAX_WAYS;
  localparam int ROW_W    = REC_OFF + MAX_WAYS * WAYW;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ} state_t;

  state_t                state_r;
  logic [SETW-1:0]       clr_r, set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [slc_pkg::COUNT_W-1:0] hits_r, misses_r, evicts_r;
  logic                  res_valid_r;
  slc_pkg::res_t         res_r;

  logic [ROW_W-1:0]      rdata, wdata, upd_row, clr_row;
  logic                  ram_we, out_free, commit;
  logic [SETW-1:0]       waddr;

  logic                  vld [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] tg  [MAX_WAYS];
  logic [WAYW-1:0]       q   [MAX_WAYS];
  logic [WAYW-1:0]       q_new [MAX_WAYS];
  logic [WCW-1:0]        ways;
  logic                  hit, free_found, evict;
  logic [WAYW-1:0]       hit_way, free_way, old_way, way;
  logic [WAYW-1:0]       pos;

  assign out_free = !res_valid_r || !res_stall;
  assign commit   = (state_r == S_READ) && out_free;
  assign req_pop  = (state_r == S_IDLE) && req_valid;
  assign clearing = (state_r == S_CLEAR);
  assign ram_we   = clearing || commit;
  assign waddr    = clearing ? clr_r : set_r;
  assign wdata    = clearing ? clr_row : upd_row;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    if (ways_in_use == 4'd0) begin
      ways = WCW'(1);
    end else if (32'(ways_in_use) > MAX_WAYS) begin
      ways = WCW'(MAX_WAYS);
    end else begin
      ways = WCW'(ways_in_use);
    end
  end

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      vld[w] = rdata[TAGS_W + w];
      tg[w]  = rdata[w*ADDR_WIDTH +: ADDR_WIDTH];
      q[w]   = rdata[REC_OFF + w*WAYW +: WAYW];
    end
    // descending scans so the lowest index wins
    hit = 1'b0;
    hit_way = '0;
    free_found = 1'b0;
    free_way = '0;
    old_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < 32'(ways) && vld[w] && tg[w] == tag_r) begin
        hit = 1'b1;
        hit_way = WAYW'(w);
      end
      if (w < 32'(ways) && !vld[w]) begin
        free_found = 1'b1;
        free_way = WAYW'(w);
      end
      if (32'(q[w]) < 32'(ways)) begin
        old_way = q[w];
      end
    end
    evict = !hit && !free_found;
    way   = hit ? hit_way : (free_found ? free_way : old_way);
    // move the touched way to the most recent end
    pos = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (q[i] == way) begin
        pos = WAYW'(i);
      end
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i < 32'(pos)) begin
        q_new[i] = q[i];
      end else if (i < MAX_WAYS - 1) begin
        q_new[i] = q[(i + 1) % MAX_WAYS];
      end else begin
        q_new[i] = way;
      end
    end
    upd_row = rdata;
    if (!hit) begin
      upd_row[32'(way)*ADDR_WIDTH +: ADDR_WIDTH] = tag_r;
      upd_row[TAGS_W + 32'(way)] = 1'b1;
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      upd_row[REC_OFF + i*WAYW +: WAYW] = q_new[i];
    end
    clr_row = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      clr_row[REC_OFF + i*WAYW +: WAYW] = WAYW'(i);
    end
  end

  slc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (req_pop),
    .raddr (req_set),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_valid_r && !res_stall && !commit) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + SETW'(1);
          if (clr_r == SETW'(NUM_SETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            set_r   <= req_set;
            tag_r   <= req_tag;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (out_free) begin
            res_valid_r       <= 1'b1;
            res_r.hit         <= hit;
            res_r.evicted     <= evict;
            res_r.way_used    <= slc_pkg::WAY_OUT_W'(way);
            res_r.set_number  <= slc_pkg::SET_OUT_W'(set_r);
            res_r.hit_count   <= (hit && hits_r != slc_pkg::COUNT_MAX) ?
                                 hits_r + 1'b1 : hits_r;
            res_r.miss_count  <= (!hit && misses_r != slc_pkg::COUNT_MAX) ?
                                 misses_r + 1'b1 : misses_r;
            res_r.eviction_count <= (evict && evicts_r != slc_pkg::COUNT_MAX) ?
                                    evicts_r + 1'b1 : evicts_r;
            if (hit && hits_r != slc_pkg::COUNT_MAX) begin
              hits_r <= hits_r + 1'b1;
            end
            if (!hit && misses_r != slc_pkg::COUNT_MAX) begin
              misses_r <= misses_r + 1'b1;
            end
            if (evict && evicts_r != slc_pkg::COUNT_MAX) begin
              evicts_r <= evicts_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/set_assoc_lru_cache_lookup.sv -----
// Set-associative cache lookup with LRU replacement: each accepted address
// request gives one result with hit/eviction flags, way, set and running counts.
// After reset a clearing pass writes every set row (2**SET_INDEX_BITS, 64 by
// default); no request is taken during it. Each request then goes through one
// registered row read and one row write with the result in the back end; the
// next is taken only after that write, one read-modify-write of a set row in
// RAM at a time. The result is registered with the row write, which waits
// while a stalled result is pending. A two-entry queue lets the input keep
// accepting while a finished result waits.
// Depends on slc_pkg, slc_front, slc_fifo, slc_back.
module set_assoc_lru_cache_lookup #(
  parameter int SET_INDEX_BITS = slc_pkg::DEF_SET_INDEX_BITS,
  parameter int MAX_WAYS       = slc_pkg::DEF_MAX_WAYS,
  parameter int ADDR_WIDTH     = slc_pkg::DEF_ADDR_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [slc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [slc_pkg::ADDR_IN_W-1:0]   in_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic                            out_evicted,
  output logic [slc_pkg::WAY_OUT_W-1:0]   out_way_used,
  output logic [slc_pkg::SET_OUT_W-1:0]   out_set_number,
  output logic [slc_pkg::COUNT_W-1:0]     out_hit_count,
  output logic [slc_pkg::COUNT_W-1:0]     out_miss_count,
  output logic [slc_pkg::COUNT_W-1:0]     out_eviction_count
);

  localparam int SETW = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
  localparam int QW   = SETW + ADDR_WIDTH;

  slc_pkg::cfg_t         cfg_r;
  slc_pkg::res_t         res;
  logic [SETW-1:0]       f_set, q_set;
  logic [ADDR_WIDTH-1:0] f_tag, q_tag;
  logic                  q_full, q_ne, q_pop, clearing, push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits    <= 3'd0;
      cfg_r.block_bits  <= 6'd0;
      cfg_r.ways_in_use <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        slc_pkg::CFG_SET_BITS:    cfg_r.set_bits    <= cfg_wdata[2:0];
        slc_pkg::CFG_BLOCK_BITS:  cfg_r.block_bits  <= cfg_wdata[5:0];
        slc_pkg::CFG_WAYS_IN_USE: cfg_r.ways_in_use <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full || clearing;
  assign push     = in_valid && !in_stall;

  slc_front #(.SET_INDEX_BITS(SET_INDEX_BITS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .address (in_address),
    .cfg     (cfg_r),
    .set_idx (f_set),
    .tag     (f_tag)
  );

  slc_fifo #(.WIDTH(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_set, f_tag}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_ne),
    .pop_data  ({q_set, q_tag})
  );

  slc_back #(
    .SET_INDEX_BITS (SET_INDEX_BITS),
    .MAX_WAYS       (MAX_WAYS),
    .ADDR_WIDTH     (ADDR_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ways_in_use (cfg_r.ways_in_use),
    .req_valid   (q_ne),
    .req_set     (q_set),
    .req_tag     (q_tag),
    .req_pop     (q_pop),
    .clearing    (clearing),
    .res_valid   (out_valid),
    .res_stall   (out_stall),
    .res         (res)
  );

  assign out_hit            = res.hit;
  assign out_evicted        = res.evicted;
  assign out_way_used       = res.way_used;
  assign out_set_number     = res.set_number;
  assign out_hit_count      = res.hit_count;
  assign out_miss_count     = res.miss_count;
  assign out_eviction_count = res.eviction_count;

endmodule

// ----- rtl/slc_checker.sv -----
// Port-level checks for set_assoc_lru_cache_lookup, bound to the top level.
// Depends on slc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_hit,
  input logic                          out_evicted,
  input logic [slc_pkg::COUNT_W-1:0]   out_miss_count,
  input logic [slc_pkg::COUNT_W-1:0]   out_eviction_count
);

  `SLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `SLC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_miss_count))
  `SLC_ASSERT_NOW(a_hit_no_evict, clk, rst_n, out_valid && out_hit, !out_evicted)
  `SLC_ASSERT_NOW(a_evict_counted, clk, rst_n, out_valid && out_evicted, out_eviction_count != 0)
  `SLC_ASSERT_NOW(a_miss_counted, clk, rst_n, out_valid && !out_hit, out_miss_count != 0)

endmodule

bind set_assoc_lru_cache_lookup slc_checker u_slc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_hit            (out_hit),
  .out_evicted        (out_evicted),
  .out_miss_count     (out_miss_count),
  .out_eviction_count (out_eviction_count)
);

// ----- tb/set_assoc_lru_cache_lookup_test.sv -----
// Testbench for set_assoc_lru_cache_lookup: drives address requests under
// several cache geometries and checks every result against a behavioural model.
// Depends on slc_pkg and the set_assoc_lru_cache_lookup RTL.
module set_assoc_lru_cache_lookup_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS = 64;
  localparam int NWAYS = 8;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [slc_pkg::CFG_IDX_W-1:0] cfg_index = slc_pkg::CFG_SET_BITS;
  logic [slc_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [slc_pkg::ADDR_IN_W-1:0] in_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit, out_evicted;
  logic [slc_pkg::WAY_OUT_W-1:0] out_way_used;
  logic [slc_pkg::SET_OUT_W-1:0] out_set_number;
  logic [slc_pkg::COUNT_W-1:0] out_hit_count, out_miss_count, out_eviction_count;

  set_assoc_lru_cache_lookup dut (.*);

  initial forever #6 clk = ~clk;

  // model state
  bit        mdl_valid [NSETS][NWAYS];
  bit [63:0] mdl_tag   [NSETS][NWAYS];
  bit [2:0]  mdl_order [NSETS][NWAYS];
  bit [31:0] n_hits, n_misses, n_evicts;
  bit [2:0]  r_set_bits;
  bit [5:0]  r_block_bits;
  bit [3:0]  r_ways = 4'd1;

  slc_pkg::res_t expected_results[$];
  int   errors = 0;
  int   sender_idle = 0, receiver_idle = 0;
  int   n_requests = 0, n_results = 0;
  longint cycles = 0;

  initial begin
    for (int s = 0; s < NSETS; s++)
      for (int w = 0; w < NWAYS; w++) mdl_order[s][w] = w[2:0];
  end

  function automatic bit [31:0] sat_inc(bit [31:0] v);
    return (v == slc_pkg::COUNT_MAX) ? v : v + 1;
  endfunction

  function automatic void move_to_mru(int s, int w);
    int p;
    p = 0;
    while (p < NWAYS && mdl_order[s][p] != w) p++;
    for (int i = p; i < NWAYS - 1; i++) mdl_order[s][i] = mdl_order[s][i+1];
    mdl_order[s][NWAYS-1] = w[2:0];
  endfunction

  function automatic slc_pkg::res_t lookup_address(bit [63:0] addr);
    slc_pkg::res_t r;
    int sb, ways, s, way;
    bit [63:0] blk, tg;
    bit found, filled;
    sb = (r_set_bits > 6) ? 6 : r_set_bits;
    ways = (r_ways == 0) ? 1 : (r_ways > NWAYS ? NWAYS : r_ways);
    blk = addr >> r_block_bits;
    s = int'(blk & ((64'd1 << sb) - 1));
    tg = blk >> sb;
    found = 0; filled = 0; way = 0;
    r = '0;
    for (int w = 0; w < ways; w++)
      if (!found && mdl_valid[s][w] && mdl_tag[s][w] == tg) begin
        found = 1; way = w;
      end
    if (found) begin
      n_hits = sat_inc(n_hits);
    end else begin
      n_misses = sat_inc(n_misses);
      for (int w = 0; w < ways; w++)
        if (!filled && !mdl_valid[s][w]) begin
          filled = 1; way = w;
        end
      if (!filled) begin
        // victim: first active way in recency order
        for (int i = NWAYS - 1; i >= 0; i--)
          if (mdl_order[s][i] < ways) way = mdl_order[s][i];
        r.evicted = 1;
        n_evicts = sat_inc(n_evicts);
      end
      mdl_valid[s][way] = 1;
      mdl_tag[s][way] = tg;
    end
    move_to_mru(s, way);
    r.hit = found;
    r.way_used = way[2:0];
    r.set_number = s[5:0];
    r.hit_count = n_hits;
    r.miss_count = n_misses;
    r.eviction_count = n_evicts;
    return r;
  endfunction

  // valid stays high on return; an idle gap in the next send or drain drops it
  task automatic send_request(bit [63:0] addr);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(lookup_address(addr));
    n_requests++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [slc_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[slc_pkg::CFG_W-1:0];
    @(negedge clk);
    if (idx == slc_pkg::CFG_SET_BITS) r_set_bits = val[2:0];
    else if (idx == slc_pkg::CFG_BLOCK_BITS) r_block_bits = val[5:0];
    else r_ways = val[3:0];
  endtask

  task automatic set_geometry(int sb, int bb, int ways);
    drain();
    write_reg(slc_pkg::CFG_SET_BITS, sb);
    write_reg(slc_pkg::CFG_BLOCK_BITS, bb);
    write_reg(slc_pkg::CFG_WAYS_IN_USE, ways);
    cfg_we <= 1'b0;
  endtask

  // receiver stall pattern
  always @(negedge clk)
    out_stall <= (receiver_idle > 0) && ($urandom_range(99) < receiver_idle);

  always @(posedge clk) begin
    slc_pkg::res_t exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_hit !== exp_r.hit) begin
          $error("hit: expected %0d got %0d", exp_r.hit, out_hit); errors++;
        end
        if (out_evicted !== exp_r.evicted) begin
          $error("evicted: expected %0d got %0d", exp_r.evicted, out_evicted); errors++;
        end
        if (out_way_used !== exp_r.way_used) begin
          $error("way_used: expected %0d got %0d", exp_r.way_used, out_way_used); errors++;
        end
        if (out_set_number !== exp_r.set_number) begin
          $error("set_number: expected %0d got %0d", exp_r.set_number, out_set_number);
          errors++;
        end
        if (out_hit_count !== exp_r.hit_count) begin
          $error("hit_count: expected %0d got %0d", exp_r.hit_count, out_hit_count); errors++;
        end
        if (out_miss_count !== exp_r.miss_count) begin
          $error("miss_count: expected %0d got %0d", exp_r.miss_count, out_miss_count);
          errors++;
        end
        if (out_eviction_count !== exp_r.eviction_count) begin
          $error("eviction_count: expected %0d got %0d", exp_r.eviction_count,
                 out_eviction_count);
          errors++;
        end
      end
    end
  end

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // address built from a small tag pool so that hits and evictions recur
  function automatic bit [63:0] pooled_address(int tags);
    int sb;
    bit [63:0] a;
    sb = (r_set_bits > 6) ? 6 : r_set_bits;
    a = (64'($urandom_range(tags - 1)) << sb) | 64'($urandom_range((1 << sb) - 1));
    return (a << r_block_bits) | (rand64() & ((64'd1 << r_block_bits) - 1));
  endfunction

  task automatic test_reset_defaults();
    send_request(64'h0);
    send_request(64'h0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF);
    send_request(64'h0);
  endtask

  task automatic test_directed_corners();
    set_geometry(7, 0, 0);      // set bits clamp to 6, ways 0 acts as one
    send_request(64'h3F);
    send_request(64'h3F);
    send_request(64'hFFFF_FFFF_FFFF_FFC0);
    set_geometry(6, 32, 15);    // ways clamp to 8
    for (int i = 0; i < 10; i++) send_request(64'(i) << 32);
    send_request(64'h0);        // hits way refreshed earlier
    send_request(64'hAAAA_5555_0000_0000);
    set_geometry(0, 63, 8);     // huge offset: every address maps to tag 0 or 1
    send_request(64'hFFFF_FFFF_FFFF_FFFF);
    send_request(64'h7FFF_FFFF_FFFF_FFFF);
    set_geometry(6, 0, 2);      // inactive ways keep their lines
    send_request(64'h0);
    send_request(64'h40);
    send_request(64'h80);
  endtask

  task automatic test_random_geometry(int count, int s_idle, int r_idle);
    int tags;
    set_geometry($urandom_range(7), $urandom_range(12), $urandom_range(15));
    sender_idle = s_idle;
    receiver_idle = r_idle;
    tags = (r_ways > 1 ? r_ways : 1) + $urandom_range(4);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) send_request(rand64());
      else send_request(pooled_address(tags));
    end
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 10; i++) send_request(pooled_address(3));
    drain();
    for (int i = 0; i < 10; i++) send_request(pooled_address(3));
  endtask

  task automatic test_counter_saturation();
    // counters cannot be preset; check the running totals over a long stream
    // of two lines sharing one set and one way instead
    set_geometry(0, 0, 1);
    for (int i = 0; i < 40; i++) send_request(64'($urandom_range(1)));
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_directed_corners();
    test_random_geometry(170, 0, 0);
    test_random_geometry(170, 70, 0);
    test_random_geometry(170, 0, 70);
    test_random_geometry(170, 34, 34);
    sender_idle = 0;
    receiver_idle = 0;
    test_pause_until_drained();
    test_counter_saturation();
    drain();
    $display("Covered %0d requests and %0d results over several cache geometries,",
             n_requests, n_results);
    $display("with idle and stall phases on both channels.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
